// ===== rtl/ocsa_pkg.sv =====
// ocsa_pkg: shared constants, opcodes and saturating arithmetic for the
// octree column scatter-accumulate block. no dependencies.
package ocsa_pkg;

	// default geometry of the feature store
	localparam int CHANNELS_DEF = 8;
	localparam int CELLS_DEF    = 4096;

	// fixed field widths
	localparam int OP_W      = 1;
	localparam int CHANNEL_W = 3;
	localparam int CELL_IN_W = 13;
	localparam int VALUE_W   = 32;
	localparam int SUM_W     = 40;

	// operation codes
	localparam logic [OP_W-1:0] OP_ACC  = 1'b0;
	localparam logic [OP_W-1:0] OP_READ = 1'b1;

	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// signed add of a column value into an entry, clamped to the entry range
	function automatic sum_t sat_add(input sum_t acc, input value_t val);
		logic signed [SUM_W:0] wide;
		sum_t res;
		wide = (SUM_W+1)'(acc) + (SUM_W+1)'(val);
		if (wide[SUM_W] != wide[SUM_W-1]) begin
			res = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			res = wide[SUM_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== rtl/octree_col_scatter_accumulate_top.sv =====
// octree_col_scatter_accumulate_top: feature store with read-modify-write
// pipeline for col2im scatter-add. depends on ocsa_pkg.
//
// usage
//  - command channel: a word is taken at a rising edge with start high and
//    busy low. op selects accumulate (value added into entry channel/cell,
//    saturating at the signed 40-bit range) or read (entry returned, then
//    cleared). target_cell of -1 marks an absent neighbour.
//  - result channel: a read gives exactly one word on sum, with done high for
//    one cycle; an accumulate gives none. invalid addresses (negative cell,
//    cell not below CELLS, channel not below CHANNELS) drop an accumulate and
//    make a read return zero without touching the store.
//  - a read word passes from stage 1 into the result register, which drives
//    done and sum. throughput: one word per cycle while busy is low, any mix
//    of operations, including repeated hits on one entry; the second store
//    access is resolved by forwarding the value being written back.
//  - the store is one single-port-write, registered-read memory of
//    2^ceil(log2 CHANNELS) * 2^ceil(log2 CELLS) entries of 40 bits (32768).
//  - reset: busy rises at once and a clearing pass writes zero to every
//    entry, one per cycle. no word is taken until it is done.
//  - the receiver cannot stall; results are never held back.
module octree_col_scatter_accumulate_top #(
	parameter int CHANNELS = ocsa_pkg::CHANNELS_DEF,
	parameter int CELLS    = ocsa_pkg::CELLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [ocsa_pkg::OP_W-1:0]            op,
	input  logic [ocsa_pkg::CHANNEL_W-1:0]       channel,
	input  logic signed [ocsa_pkg::CELL_IN_W-1:0] target_cell,
	input  logic signed [ocsa_pkg::VALUE_W-1:0]  value,
	output logic                                 done,
	output logic signed [ocsa_pkg::SUM_W-1:0]    sum
);
	import ocsa_pkg::*;

	// address layout: channel in the upper bits, cell in the lower bits
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ADDR_W = CH_W + CELL_W;
	localparam int DEPTH  = 2 ** ADDR_W;

	// feature store
	sum_t mem [DEPTH];

	// clearing pass after reset
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// command decode
	logic              accept;
	logic [31:0]       ch_ext;
	logic [31:0]       cell_ext;
	logic              in_ok;
	logic [ADDR_W-1:0] in_addr;

	// stage 1: read data back from the store, modify, write
	logic              v_s1;
	logic [OP_W-1:0]   op_s1;
	logic              ok_s1;
	logic [ADDR_W-1:0] addr_s1;
	value_t            val_s1;
	sum_t              rd_s1;
	logic              fwd_s1;
	sum_t              fwd_data_s1;

	sum_t              old_val;
	sum_t              new_val;
	logic              wb_en;

	// memory write port
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	sum_t              mem_wdata;

	// result register
	logic              done_q;
	sum_t              sum_q;

	assign busy   = clr_q;
	assign accept = start && !clr_q;

	// bounds check; the cell field is signed, so -1 and any negative fail
	assign ch_ext   = 32'(channel);
	assign cell_ext = 32'(target_cell[CELL_IN_W-2:0]);
	assign in_ok    = (ch_ext < 32'(CHANNELS)) && !target_cell[CELL_IN_W-1]
		&& (cell_ext < 32'(CELLS));
	assign in_addr  = {ch_ext[CH_W-1:0], cell_ext[CELL_W-1:0]};

	// clearing sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// stage 1 payload; forward the value written this cycle if the next word
	// hits the same entry, since the store read sees the old contents
	always_ff @(posedge clk) begin
		op_s1       <= op;
		ok_s1       <= in_ok;
		addr_s1     <= in_addr;
		val_s1      <= value;
		fwd_s1      <= wb_en && (addr_s1 == in_addr);
		fwd_data_s1 <= new_val;
	end

	// modify
	assign old_val = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign new_val = (op_s1 == OP_READ) ? '0 : sat_add(old_val, val_s1);
	assign wb_en   = v_s1 && ok_s1;

	// write port: clearing pass or write-back
	always_comb begin
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wb_en;
			mem_waddr = addr_s1;
			mem_wdata = new_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= mem[in_addr];
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1 && (op_s1 == OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= ok_s1 ? old_val : '0;
	end

	assign done = done_q;
	assign sum  = sum_q;

	// no word in flight while the store is being cleared
	a_clr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!v_s1 && !done_q))
		else $error("word in flight during clearing pass");

	// a result only follows a read in stage 1
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(v_s1 && (op_s1 == OP_READ)))
		else $error("result without a read");

	// forwarding only when the previous word wrote back to the store
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && fwd_s1) |-> $past(wb_en && v_s1))
		else $error("forward without a preceding write-back");

	// a read of a valid entry leaves it cleared for the following word
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_en && (op_s1 == OP_READ)) |-> (new_val == '0))
		else $error("read did not clear entry");

endmodule

// ===== tb/feature_store_checker.sv =====
// feature_store_checker: shadow copy of the feature store that predicts each read word
// and compares it with the result channel of the scatter-accumulate block.
// depends on ocsa_pkg.
module feature_store_checker #(
	parameter int CHANNELS = ocsa_pkg::CHANNELS_DEF,
	parameter int CELLS    = ocsa_pkg::CELLS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic [ocsa_pkg::OP_W-1:0]             op,
	input  logic [ocsa_pkg::CHANNEL_W-1:0]        channel,
	input  logic signed [ocsa_pkg::CELL_IN_W-1:0] target_cell,
	input  logic signed [ocsa_pkg::VALUE_W-1:0]   value,
	input  logic                                  done,
	input  logic signed [ocsa_pkg::SUM_W-1:0]     sum,
	output int                                    errors,
	output int                                    reads_due
);
	import ocsa_pkg::*;

	localparam longint ENTRY_MAX = (longint'(1) <<< (SUM_W-1)) - 1;
	localparam longint ENTRY_MIN = -(longint'(1) <<< (SUM_W-1));

	// entries never written read as zero, which is what the clearing pass leaves
	sum_t shadow_entries [int];
	sum_t sums_due [$];
	int   fail_count = 0;

	assign errors = fail_count;

	function automatic sum_t add_clamped(input sum_t acc, input value_t val);
		longint total;
		total = longint'(acc) + longint'(val);
		if (total > ENTRY_MAX) begin
			total = ENTRY_MAX;
		end else if (total < ENTRY_MIN) begin
			total = ENTRY_MIN;
		end
		return sum_t'(total);
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		sum_t want;
		sum_t held;
		int   addr;
		bit   hit;
		if (arst_n) begin
			// results first: a word taken at this edge cannot be answered at it
			if (done) begin
				if (sums_due.size() == 0) begin
					report_mismatch($sformatf("sum %0d with no read waiting", sum));
				end else begin
					want = sums_due.pop_front();
					if (sum !== want)
						report_mismatch($sformatf("sum %0d, expected %0d", sum, want));
				end
			end
			if (start && !busy) begin
				hit  = (target_cell >= 0) && (int'(target_cell) < CELLS) &&
					(int'(channel) < CHANNELS);
				addr = int'(channel) * CELLS + int'(target_cell);
				held = (hit && shadow_entries.exists(addr)) ? shadow_entries[addr] : sum_t'(0);
				if (op == OP_ACC) begin
					if (hit)
						shadow_entries[addr] = add_clamped(held, value);
				end else begin
					sums_due = {sums_due, held};
					if (hit)
						shadow_entries.delete(addr);
				end
			end
		end
		reads_due = sums_due.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for octree_col_scatter_accumulate_top.
// depends on ocsa_pkg, the block itself and feature_store_checker.
module tb_top;
	import ocsa_pkg::*;

	// cycles with no word taken on either side before the run is called hung;
	// the clearing pass after reset counts towards it as well
	localparam int QUIET_LIMIT  = 150000;
	localparam int RANDOM_WORDS = 1250;
	localparam int SAT_RUN      = 262;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [OP_W-1:0]             op;
	logic [CHANNEL_W-1:0]        channel;
	logic signed [CELL_IN_W-1:0] target_cell;
	logic signed [VALUE_W-1:0]   value;
	logic                        done;
	logic signed [SUM_W-1:0]     sum;

	int fail_count;
	int reads_due;
	int quiet_cycles = 0;
	int words_sent   = 0;
	bit gaps_on      = 1'b1;

	octree_col_scatter_accumulate_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.channel     (channel),
		.target_cell (target_cell),
		.value       (value),
		.done        (done),
		.sum         (sum)
	);

	feature_store_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.channel     (channel),
		.target_cell (target_cell),
		.value       (value),
		.done        (done),
		.sum         (sum),
		.errors      (fail_count),
		.reads_due   (reads_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hang guard: any word taken, in or out, restarts the count
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("octree_col_scatter_accumulate_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one command word; random idle cycles go in front of it while gaps are on
	task automatic send_word(input logic [OP_W-1:0] w_op, input int w_ch, input int w_cell,
		input logic signed [VALUE_W-1:0] w_val);
		while (gaps_on && $urandom_range(99) < 30) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start       <= 1'b1;
		op          <= w_op;
		channel     <= w_ch[CHANNEL_W-1:0];
		target_cell <= w_cell[CELL_IN_W-1:0];
		value       <= w_val;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	// hold off the sender until every read word has come back
	task automatic wait_reads_drained();
		@(negedge clk);
		start <= 1'b0;
		while (reads_due != 0) @(negedge clk);
	endtask

	// full-range column value, with the extremes and zero now and then
	function automatic logic signed [VALUE_W-1:0] pick_value();
		unique case ($urandom_range(9))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return '0;
			default: return $urandom();
		endcase
	endfunction

	// one octree as the feeder produces it: a handful of cells and channels get
	// column values (some neighbours absent), then every touched entry is read out
	task automatic octree_pass();
		int base_cell;
		int n_cells;
		int first_ch;
		int n_ch;
		int n_acc;
		int cell_idx;
		base_cell = $urandom_range(CELLS_DEF - 8);
		n_cells   = $urandom_range(1, 4);
		first_ch  = $urandom_range(CHANNELS_DEF - 1);
		n_ch      = $urandom_range(1, 2);
		n_acc     = $urandom_range(2, 24);
		repeat (n_acc) begin
			cell_idx = ($urandom_range(99) < 15) ? -1 : base_cell + $urandom_range(n_cells - 1);
			send_word(OP_ACC, (first_ch + $urandom_range(n_ch - 1)) % CHANNELS_DEF, cell_idx,
				pick_value());
		end
		for (int c = 0; c < n_ch; c++) begin
			for (int k = 0; k < n_cells; k++)
				send_word(OP_READ, (first_ch + c) % CHANNELS_DEF, base_cell + k, pick_value());
		end
	endtask

	// anything the fields allow, negative cells included
	task automatic noise_word();
		int raw_cell;
		raw_cell = $urandom_range(8191);
		send_word(OP_W'($urandom_range(1)), $urandom_range(CHANNELS_DEF - 1),
			(raw_cell >= 4096) ? raw_cell - 8192 : raw_cell, pick_value());
	endtask

	// drives one entry past the signed 40-bit range, reads it, then checks it
	// starts again from zero
	task automatic saturate_entry(input bit upward);
		int ch;
		int cell_idx;
		ch       = $urandom_range(CHANNELS_DEF - 1);
		cell_idx = $urandom_range(CELLS_DEF - 1);
		repeat (SAT_RUN)
			send_word(OP_ACC, ch, cell_idx, upward ? 32'sh7fff_ffff - $urandom_range(15) :
				32'sh8000_0000 + $urandom_range(15));
		send_word(OP_READ, ch, cell_idx, '0);
		send_word(OP_ACC, ch, cell_idx, pick_value());
		send_word(OP_READ, ch, cell_idx, '0);
	endtask

	initial begin
		int word_goal;
		start       = 1'b0;
		op          = OP_ACC;
		channel     = '0;
		target_cell = '0;
		value       = '0;
		arst_n      = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words: extremes, repeated hits on one entry,
		// read-and-clear, absent neighbour and other invalid cells
		send_word(OP_READ, 0, 0, '0);
		send_word(OP_ACC,  0, 0, 32'sh7fff_ffff);
		send_word(OP_ACC,  0, 0, 32'sh7fff_ffff);
		send_word(OP_READ, 0, 0, '0);
		send_word(OP_READ, 0, 0, '1);
		send_word(OP_ACC,  7, 4095, 32'sh8000_0000);
		send_word(OP_ACC,  7, 4095, -32'sd1);
		send_word(OP_READ, 7, 4095, '0);
		send_word(OP_ACC,  3, -1, 32'sd12345);
		send_word(OP_READ, 3, -1, '0);
		send_word(OP_ACC,  5, -4096, 32'sh7fff_ffff);
		send_word(OP_READ, 5, -4096, '0);
		send_word(OP_ACC,  2, 100, 32'sh5555_5555);
		send_word(OP_READ, 2, 100, '0);
		send_word(OP_ACC,  2, 100, 32'shaaaa_aaaa);
		send_word(OP_ACC,  2, 100, '0);
		send_word(OP_READ, 2, 100, '0);
		send_word(OP_ACC,  6, 2048, 32'sd1);
		send_word(OP_READ, 6, 2048, '0);
		send_word(OP_READ, 6, 2048, '0);
		send_word(OP_READ, 1, -2, '0);
		send_word(OP_READ, 4, 4096 - 2, '0);
		wait_reads_drained();

		// random part: mostly whole octrees, some noise, two saturation runs,
		// and a stretch with the sender never idle
		word_goal = words_sent + RANDOM_WORDS;
		for (int round = 0; words_sent < word_goal; round++) begin
			gaps_on = !(words_sent > 700 && words_sent < 950);
			if (round == 5) begin
				saturate_entry(1'b1);
			end else if (round == 30) begin
				wait_reads_drained();
				saturate_entry(1'b0);
			end else if ($urandom_range(99) < 75) begin
				octree_pass();
			end else begin
				noise_word();
			end
		end

		// drain, then leave room for any stray result word
		wait_reads_drained();
		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("octree_col_scatter_accumulate_top test passed");
		end else begin
			$display("octree_col_scatter_accumulate_top test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ocsa_pkg.sv
rtl/octree_col_scatter_accumulate_top.sv
tb/feature_store_checker.sv
tb/tb_top.sv
